// ----- hdl/rcdc_pkg.sv -----
// ---------------------------------------------------------------------------
// rcdc_pkg: shared types and constants
// Widths, payload structs, register indexes and reciprocal constants for the
// radio clock drift calibrator.
// ---------------------------------------------------------------------------
package rcdc_pkg;

  // Frames per averaging window
  localparam int HISTORY_DEPTH = 10;
  localparam int DW            = $clog2(HISTORY_DEPTH);

  // Field widths
  localparam int LEN_W  = 7;
  localparam int IF_W   = 16;
  localparam int FO_W   = 8;
  localparam int CNT_W  = 24;
  localparam int SET_W  = 16;
  localparam int TRIM_W = 5;

  // Running sums hold a full window exactly
  localparam int IF_SUM_W  = IF_W + DW;
  localparam int OFS_SUM_W = FO_W + DW;
  localparam int CNT_SUM_W = CNT_W + DW;
  localparam int SMP_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  // Frame and correction constants
  localparam logic [LEN_W-1:0]  ACCEPT_LENGTH  = LEN_W'(5);
  localparam int                IF_CENTRE      = 500;
  localparam int                IF_STEP        = 17;
  localparam int                FO_CENTRE      = 2;
  localparam int                FO_STEP        = 10;
  localparam int                COARSE_STEP    = 331;
  localparam int                FINE_STEP      = 58;
  localparam logic [TRIM_W-1:0] EDGE_HIGH      = TRIM_W'(30);
  localparam logic [TRIM_W-1:0] EDGE_LOW       = TRIM_W'(2);
  localparam logic [SET_W-1:0]  RX_EDGE_OFFSET = SET_W'(32 - 6);
  localparam logic [SET_W-1:0]  TX_EDGE_OFFSET = SET_W'(32 - 8);
  localparam logic [TRIM_W-1:0] TRIM_MAX       = TRIM_W'(31);

  // Reset values
  localparam logic [CNT_W-1:0]  TARGET_RESET  = CNT_W'(60000);
  localparam logic [SET_W-1:0]  SETTING_RESET = SET_W'(24576);
  localparam logic [TRIM_W-1:0] TRIM_RESET    = '0;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CNT_W;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RX_DEFAULT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RX_ALTERNATE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TX_DEFAULT   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TX_ALTERNATE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_INIT  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_FINE_INIT    = CFG_IDX_W'(6);

  // Constant division: q = (x * MUL) >> SH, exact for x < 2^XW when
  // SH = XW + ceil(log2(d)) and MUL = ceil(2^SH / d).
  // Window averages
  localparam int AIF_SH = IF_SUM_W + DW;
  localparam int AIF_MW = IF_SUM_W + 1;
  localparam int AIF_PW = IF_SUM_W + AIF_MW;
  localparam logic [AIF_MW-1:0] AIF_MUL = AIF_MW'(((64'd1 << AIF_SH)
      + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  localparam int AFO_SH = OFS_SUM_W + DW;
  localparam int AFO_MW = OFS_SUM_W + 1;
  localparam int AFO_PW = OFS_SUM_W + AFO_MW;
  localparam logic [AFO_MW-1:0] AFO_MUL = AFO_MW'(((64'd1 << AFO_SH)
      + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  localparam int ACN_SH = CNT_SUM_W + DW;
  localparam int ACN_MW = CNT_SUM_W + 1;
  localparam int ACN_PW = CNT_SUM_W + ACN_MW;
  localparam logic [ACN_MW-1:0] ACN_MUL = ACN_MW'(((64'd1 << ACN_SH)
      + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  // RX step: magnitude of (avg_if - 500) fits 16 bits
  localparam int RXQ_XW = IF_W;
  localparam int RXQ_SH = RXQ_XW + $clog2(IF_STEP);
  localparam int RXQ_MW = RXQ_XW + 1;
  localparam int RXQ_PW = RXQ_XW + RXQ_MW;
  localparam int RXQ_QW = RXQ_PW - RXQ_SH;
  localparam logic [RXQ_MW-1:0] RXQ_MUL = RXQ_MW'(((64'd1 << RXQ_SH)
      + 64'(IF_STEP) - 64'd1) / 64'(IF_STEP));

  // TX step: magnitude of (avg_fo - 2) is at most 130
  localparam int TXQ_XW = FO_W;
  localparam int TXQ_SH = TXQ_XW + $clog2(FO_STEP);
  localparam int TXQ_MW = TXQ_XW + 1;
  localparam int TXQ_PW = TXQ_XW + TXQ_MW;
  localparam int TXQ_QW = TXQ_PW - TXQ_SH;
  localparam logic [TXQ_MW-1:0] TXQ_MUL = TXQ_MW'(((64'd1 << TXQ_SH)
      + 64'(FO_STEP) - 64'd1) / 64'(FO_STEP));

  // Coarse step on the count error magnitude
  localparam int CRQ_XW = CNT_W;
  localparam int CRQ_SH = CRQ_XW + $clog2(COARSE_STEP);
  localparam int CRQ_MW = CRQ_XW + 1;
  localparam int CRQ_PW = CRQ_XW + CRQ_MW;
  localparam int CRQ_QW = CRQ_PW - CRQ_SH;
  localparam logic [CRQ_MW-1:0] CRQ_MUL = CRQ_MW'(((64'd1 << CRQ_SH)
      + 64'(COARSE_STEP) - 64'd1) / 64'(COARSE_STEP));

  // Fine step on the coarse remainder
  localparam int FNQ_XW = $clog2(COARSE_STEP);
  localparam int FNQ_SH = FNQ_XW + $clog2(FINE_STEP);
  localparam int FNQ_MW = FNQ_XW + 1;
  localparam int FNQ_PW = FNQ_XW + FNQ_MW;
  localparam int FNQ_QW = FNQ_PW - FNQ_SH;
  localparam logic [FNQ_MW-1:0] FNQ_MUL = FNQ_MW'(((64'd1 << FNQ_SH)
      + 64'(FINE_STEP) - 64'd1) / 64'(FINE_STEP));

  // Trim update sum, wide enough for the coarse step
  localparam int TSUM_W = CRQ_QW + 2;

  // Payload types
  typedef struct packed {
    logic                    crc_good;
    logic [LEN_W-1:0]        frame_length;
    logic [IF_W-1:0]         if_estimate;
    logic signed [FO_W-1:0]  freq_offset;
    logic [CNT_W-1:0]        osc_count;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               update_done;
    logic [SET_W-1:0]   active_tx_setting;
    logic [SET_W-1:0]   active_rx_setting;
    logic [TRIM_W-1:0]  coarse_trim;
    logic [TRIM_W-1:0]  fine_trim;
    logic               active_pair;
  } result_t;

  // Front to back command
  typedef struct packed {
    logic                         ok;
    logic                         upd;
    logic [IF_SUM_W-1:0]          if_sum;
    logic signed [OFS_SUM_W-1:0]  ofs_sum;
    logic [CNT_SUM_W-1:0]         cnt_sum;
  } cmd_t;

  // Configuration write
  typedef struct packed {
    logic                   valid;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_t;

  typedef logic [1:0][SET_W-1:0] cand_pair_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_AVG,
    B_DIFF,
    B_QUOT,
    B_REM,
    B_APPLY,
    B_FIX
  } back_state_t;

endpackage

// ----- hdl/radio_clock_drift_calibrator.sv -----
// ---------------------------------------------------------------------------
// radio_clock_drift_calibrator: acknowledgement-driven oscillator calibration
// Averages IF estimate, frequency offset and 2 MHz count over a window of
// good frames and corrects the RX/TX candidate settings and RC trims.
// ---------------------------------------------------------------------------
// Every frame transfer on the input queue yields exactly one result transfer,
// in order. A frame counts only with a good CRC and a length of 5 bytes; each
// result reports whether it counted, whether it closed a window, and the
// active TX/RX settings, RC trims and active pair as they stand after it.
// Ordinary frames flow at one per clock while results are popped and no
// window update is running, passing through the command queue and the
// result register. The frame that closes a window (every HISTORY_DEPTH
// counted frames) steps the correction sequencer through latch, the three
// window averages, the offsets from centre, the three step quotients
// (reciprocal multiplies), applying RX, TX and coarse while forming the
// coarse remainder, the fine quotient, and applying fine, toggling the pair,
// re-centring edge candidates and posting the result. A 4-entry command
// queue lets frames keep arriving meanwhile. Configuration writes are always
// ready and load the matching live state at once; write them only while no
// frame is in flight.
// ---------------------------------------------------------------------------
module radio_clock_drift_calibrator (
  input  logic                                 clk,
  input  logic                                 rst,
  // frame input queue
  input  logic                                 push,
  output logic                                 full,
  input  rcdc_pkg::item_t                      item,
  // result output queue
  output logic                                 empty,
  input  logic                                 pop,
  output rcdc_pkg::result_t                    result,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rcdc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rcdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic              q_full;
  logic              q_push;
  rcdc_pkg::cmd_t    q_wr_data;
  logic              q_valid;
  logic              q_pop;
  rcdc_pkg::cmd_t    q_rd_data;
  rcdc_pkg::cfg_t    cfg;

  // No backpressure on configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.valid = cfg_valid;
    cfg.index = cfg_index;
    cfg.data  = cfg_data;
  end

  // Front: filter and accumulate, one command per frame transfer
  rcdc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  // Decouples frame intake from the multi-cycle window update
  rcdc_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd      (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  // Back: corrections, settings state and the result register
  rcdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (q_rd_data),
    .cmd_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

// ----- hdl/rcdc_front.sv -----
// ---------------------------------------------------------------------------
// rcdc_front: frame filter and window accumulator
// Accepts frames, checks CRC and length, keeps the running sums and hands
// one command per frame to the back end, with the full sums on window close.
// ---------------------------------------------------------------------------
module rcdc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  rcdc_pkg::item_t      item,
  input  logic                 q_full,
  output logic                 q_push,
  output rcdc_pkg::cmd_t       q_data
);

  logic [rcdc_pkg::IF_SUM_W-1:0]         if_sum;
  logic signed [rcdc_pkg::OFS_SUM_W-1:0] ofs_sum;
  logic [rcdc_pkg::CNT_SUM_W-1:0]        cnt_sum;
  logic [rcdc_pkg::SMP_W-1:0]            samples;

  logic [rcdc_pkg::IF_SUM_W-1:0]         if_sum_next;
  logic signed [rcdc_pkg::OFS_SUM_W-1:0] ofs_sum_next;
  logic [rcdc_pkg::CNT_SUM_W-1:0]        cnt_sum_next;
  logic                                  ok;
  logic                                  last;
  logic                                  take;

  assign full = q_full;
  assign take = push && !q_full;
  assign ok   = item.crc_good && (item.frame_length == rcdc_pkg::ACCEPT_LENGTH);
  assign last = (samples == rcdc_pkg::SMP_W'(rcdc_pkg::HISTORY_DEPTH - 1));

  // freq_offset is signed: the sized cast sign-extends
  assign if_sum_next  = if_sum + rcdc_pkg::IF_SUM_W'(item.if_estimate);
  assign ofs_sum_next = ofs_sum + rcdc_pkg::OFS_SUM_W'(item.freq_offset);
  assign cnt_sum_next = cnt_sum + rcdc_pkg::CNT_SUM_W'(item.osc_count);

  always_comb begin
    q_push         = take;
    q_data.ok      = ok;
    q_data.upd     = ok && last;
    q_data.if_sum  = if_sum_next;
    q_data.ofs_sum = ofs_sum_next;
    q_data.cnt_sum = cnt_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      if_sum  <= '0;
      ofs_sum <= '0;
      cnt_sum <= '0;
      samples <= '0;
    end else if (take && ok) begin
      if (last) begin
        if_sum  <= '0;
        ofs_sum <= '0;
        cnt_sum <= '0;
        samples <= '0;
      end else begin
        if_sum  <= if_sum_next;
        ofs_sum <= ofs_sum_next;
        cnt_sum <= cnt_sum_next;
        samples <= samples + rcdc_pkg::SMP_W'(1);
      end
    end
  end

endmodule

// ----- hdl/rcdc_cmd_queue.sv -----
// ---------------------------------------------------------------------------
// rcdc_cmd_queue: command queue
// Small register FIFO between front and back so each side stalls alone.
// ---------------------------------------------------------------------------
module rcdc_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  rcdc_pkg::cmd_t  wr_data,
  output logic            full,
  input  logic            rd,
  output logic            valid,
  output rcdc_pkg::cmd_t  rd_data
);

  rcdc_pkg::cmd_t                mem [rcdc_pkg::QUEUE_DEPTH];
  logic [rcdc_pkg::QA_W-1:0]     wr_ptr;
  logic [rcdc_pkg::QA_W-1:0]     rd_ptr;
  logic [rcdc_pkg::QC_W-1:0]     fill;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (fill == rcdc_pkg::QC_W'(rcdc_pkg::QUEUE_DEPTH));
  assign valid   = (fill != '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;

  function automatic logic [rcdc_pkg::QA_W-1:0] ptr_inc(input logic [rcdc_pkg::QA_W-1:0] p);
    if (p == rcdc_pkg::QA_W'(rcdc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + rcdc_pkg::QA_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + rcdc_pkg::QC_W'(1);
        2'b01:   fill <= fill - rcdc_pkg::QC_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/rcdc_back.sv -----
// ---------------------------------------------------------------------------
// rcdc_back: correction engine
// Holds the candidate settings and trims, runs the window update as a short
// step sequence and keeps the result register toward the output.
// ---------------------------------------------------------------------------
module rcdc_back (
  input  logic               clk,
  input  logic               rst,
  input  rcdc_pkg::cfg_t     cfg,
  input  logic               cmd_valid,
  input  rcdc_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output rcdc_pkg::result_t  result
);

  rcdc_pkg::back_state_t state, state_next;

  // Architectural state
  logic [rcdc_pkg::CNT_W-1:0]   target;
  rcdc_pkg::cand_pair_t         rx_cand;
  rcdc_pkg::cand_pair_t         tx_cand;
  logic                         pair;
  logic [rcdc_pkg::TRIM_W-1:0]  coarse;
  logic [rcdc_pkg::TRIM_W-1:0]  fine;

  // Result register
  logic                         out_valid;
  rcdc_pkg::result_t            out_data;

  // Update work registers
  logic [rcdc_pkg::IF_SUM_W-1:0]   w_if;
  logic [rcdc_pkg::OFS_SUM_W-1:0]  w_ofs_mag;
  logic                            w_ofs_neg;
  logic [rcdc_pkg::CNT_SUM_W-1:0]  w_cnt;
  logic [rcdc_pkg::IF_W-1:0]       avg_if;
  logic [rcdc_pkg::FO_W-1:0]       avg_fo_mag;
  logic                            avg_fo_neg;
  logic [rcdc_pkg::CNT_W-1:0]      avg_cnt;
  logic [rcdc_pkg::RXQ_XW-1:0]     a_mag;
  logic                            a_neg;
  logic [rcdc_pkg::TXQ_XW-1:0]     b_mag;
  logic                            b_neg;
  logic [rcdc_pkg::CRQ_XW-1:0]     e_mag;
  logic                            e_neg;
  logic [rcdc_pkg::RXQ_QW-1:0]     q_rx;
  logic [rcdc_pkg::TXQ_QW-1:0]     q_tx;
  logic [rcdc_pkg::CRQ_QW-1:0]     q_c;
  logic [rcdc_pkg::FNQ_XW-1:0]     rem;
  logic [rcdc_pkg::FNQ_QW-1:0]     q_f;

  // Control from the sequencer
  logic                 slot_free;
  logic                 load_out;
  rcdc_pkg::result_t    out_next;
  logic                 start_upd;

  // Datapath intermediates
  logic [rcdc_pkg::AIF_PW-1:0]     aif_prod;
  logic [rcdc_pkg::AFO_PW-1:0]     afo_prod;
  logic [rcdc_pkg::ACN_PW-1:0]     acn_prod;
  logic [rcdc_pkg::RXQ_PW-1:0]     rxq_prod;
  logic [rcdc_pkg::TXQ_PW-1:0]     txq_prod;
  logic [rcdc_pkg::CRQ_PW-1:0]     crq_prod;
  logic [rcdc_pkg::FNQ_PW-1:0]     fnq_prod;
  logic [rcdc_pkg::OFS_SUM_W-1:0]  ofs_mag_in;
  logic [rcdc_pkg::IF_W:0]         a_diff;
  logic signed [rcdc_pkg::FO_W:0]  avg_fo_s;
  logic signed [rcdc_pkg::FO_W:0]  b_diff;
  logic [rcdc_pkg::CNT_W:0]        e_diff;
  logic [rcdc_pkg::CNT_W-1:0]      c_back;
  logic [rcdc_pkg::SET_W-1:0]      rx_adj;
  logic [rcdc_pkg::SET_W-1:0]      tx_adj;
  logic [rcdc_pkg::TRIM_W-1:0]     fine_upd;
  rcdc_pkg::cand_pair_t            rx_fix;
  rcdc_pkg::cand_pair_t            tx_fix;

  // Add a signed step to a trim and clamp to 0..31
  function automatic logic [rcdc_pkg::TRIM_W-1:0] trim_add(
    input logic [rcdc_pkg::TRIM_W-1:0] v,
    input logic [rcdc_pkg::CRQ_QW-1:0] mag,
    input logic                        neg
  );
    logic signed [rcdc_pkg::TSUM_W-1:0] s;
    logic signed [rcdc_pkg::TSUM_W-1:0] d;
    d = $signed(rcdc_pkg::TSUM_W'(mag));
    s = $signed(rcdc_pkg::TSUM_W'(v)) + (neg ? -d : d);
    if (s < 0) begin
      return '0;
    end
    if (s > $signed(rcdc_pkg::TSUM_W'(rcdc_pkg::TRIM_MAX))) begin
      return rcdc_pkg::TRIM_MAX;
    end
    return rcdc_pkg::TRIM_W'(s);
  endfunction

  // Re-centre the first candidate whose fine field sits at an edge
  function automatic rcdc_pkg::cand_pair_t edge_fix(
    input rcdc_pkg::cand_pair_t        c,
    input logic [rcdc_pkg::SET_W-1:0]  step
  );
    rcdc_pkg::cand_pair_t             r;
    logic [rcdc_pkg::TRIM_W-1:0]      f0;
    logic [rcdc_pkg::TRIM_W-1:0]      f1;
    r  = c;
    f0 = c[0][rcdc_pkg::TRIM_W-1:0];
    f1 = c[1][rcdc_pkg::TRIM_W-1:0];
    if (f0 >= rcdc_pkg::EDGE_HIGH) begin
      r[0] = c[1] + step;
    end else if (f0 <= rcdc_pkg::EDGE_LOW) begin
      r[0] = c[1] - step;
    end else if (f1 >= rcdc_pkg::EDGE_HIGH) begin
      r[1] = c[0] + step;
    end else if (f1 <= rcdc_pkg::EDGE_LOW) begin
      r[1] = c[0] - step;
    end
    return r;
  endfunction

  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign result    = out_data;

  // Reciprocal multipliers, one per lane and step
  assign aif_prod = rcdc_pkg::AIF_PW'(w_if) * rcdc_pkg::AIF_PW'(rcdc_pkg::AIF_MUL);
  assign afo_prod = rcdc_pkg::AFO_PW'(w_ofs_mag) * rcdc_pkg::AFO_PW'(rcdc_pkg::AFO_MUL);
  assign acn_prod = rcdc_pkg::ACN_PW'(w_cnt) * rcdc_pkg::ACN_PW'(rcdc_pkg::ACN_MUL);
  assign rxq_prod = rcdc_pkg::RXQ_PW'(a_mag) * rcdc_pkg::RXQ_PW'(rcdc_pkg::RXQ_MUL);
  assign txq_prod = rcdc_pkg::TXQ_PW'(b_mag) * rcdc_pkg::TXQ_PW'(rcdc_pkg::TXQ_MUL);
  assign crq_prod = rcdc_pkg::CRQ_PW'(e_mag) * rcdc_pkg::CRQ_PW'(rcdc_pkg::CRQ_MUL);
  assign fnq_prod = rcdc_pkg::FNQ_PW'(rem) * rcdc_pkg::FNQ_PW'(rcdc_pkg::FNQ_MUL);

  assign ofs_mag_in = cmd.ofs_sum[rcdc_pkg::OFS_SUM_W-1] ?
                      rcdc_pkg::OFS_SUM_W'(-cmd.ofs_sum) :
                      rcdc_pkg::OFS_SUM_W'(cmd.ofs_sum);

  // Signed offsets from the centres
  assign a_diff   = {1'b0, avg_if} - (rcdc_pkg::IF_W + 1)'(rcdc_pkg::IF_CENTRE);
  assign avg_fo_s = avg_fo_neg ? -$signed({1'b0, avg_fo_mag}) : $signed({1'b0, avg_fo_mag});
  assign b_diff   = avg_fo_s - (rcdc_pkg::FO_W + 1)'(rcdc_pkg::FO_CENTRE);
  assign e_diff   = {1'b0, avg_cnt} - {1'b0, target};

  // Coarse quotient times the step, taken back off the error
  assign c_back = rcdc_pkg::CNT_W'(rcdc_pkg::CNT_W'(q_c)
                                   * rcdc_pkg::CNT_W'(rcdc_pkg::COARSE_STEP));

  assign rx_adj = a_neg ? -rcdc_pkg::SET_W'(q_rx) : rcdc_pkg::SET_W'(q_rx);
  assign tx_adj = b_neg ? -rcdc_pkg::SET_W'(q_tx) : rcdc_pkg::SET_W'(q_tx);

  assign fine_upd = trim_add(fine, rcdc_pkg::CRQ_QW'(q_f), e_neg);
  assign rx_fix   = edge_fix(rx_cand, rcdc_pkg::RX_EDGE_OFFSET);
  assign tx_fix   = edge_fix(tx_cand, rcdc_pkg::TX_EDGE_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcdc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    load_out   = 1'b0;
    start_upd  = 1'b0;
    out_next.accepted          = cmd.ok;
    out_next.update_done       = 1'b0;
    out_next.active_tx_setting = tx_cand[pair];
    out_next.active_rx_setting = rx_cand[pair];
    out_next.coarse_trim       = coarse;
    out_next.fine_trim         = fine;
    out_next.active_pair       = pair;
    unique case (state)
      rcdc_pkg::B_IDLE: begin
        // A command is taken only with the result register free; it stays free through an update
        if (cmd_valid && slot_free) begin
          cmd_pop = 1'b1;
          if (cmd.upd) begin
            start_upd  = 1'b1;
            state_next = rcdc_pkg::B_AVG;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      rcdc_pkg::B_AVG:   state_next = rcdc_pkg::B_DIFF;
      rcdc_pkg::B_DIFF:  state_next = rcdc_pkg::B_QUOT;
      rcdc_pkg::B_QUOT:  state_next = rcdc_pkg::B_REM;
      rcdc_pkg::B_REM:   state_next = rcdc_pkg::B_APPLY;
      rcdc_pkg::B_APPLY: state_next = rcdc_pkg::B_FIX;
      rcdc_pkg::B_FIX: begin
        load_out                   = 1'b1;
        out_next.accepted          = 1'b1;
        out_next.update_done       = 1'b1;
        out_next.active_tx_setting = tx_fix[~pair];
        out_next.active_rx_setting = rx_fix[~pair];
        out_next.fine_trim         = fine_upd;
        out_next.active_pair       = ~pair;
        state_next                 = rcdc_pkg::B_IDLE;
      end
      default: state_next = rcdc_pkg::B_IDLE;
    endcase
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (start_upd) begin
      w_if      <= cmd.if_sum;
      w_ofs_mag <= ofs_mag_in;
      w_ofs_neg <= cmd.ofs_sum[rcdc_pkg::OFS_SUM_W-1];
      w_cnt     <= cmd.cnt_sum;
    end
    if (state == rcdc_pkg::B_AVG) begin
      avg_if     <= aif_prod[rcdc_pkg::AIF_SH +: rcdc_pkg::IF_W];
      avg_fo_mag <= afo_prod[rcdc_pkg::AFO_SH +: rcdc_pkg::FO_W];
      avg_fo_neg <= w_ofs_neg;
      avg_cnt    <= acn_prod[rcdc_pkg::ACN_SH +: rcdc_pkg::CNT_W];
    end
    if (state == rcdc_pkg::B_DIFF) begin
      a_neg <= a_diff[rcdc_pkg::IF_W];
      a_mag <= a_diff[rcdc_pkg::IF_W] ? rcdc_pkg::RXQ_XW'(-a_diff)
                                      : rcdc_pkg::RXQ_XW'(a_diff);
      b_neg <= b_diff[rcdc_pkg::FO_W];
      b_mag <= b_diff[rcdc_pkg::FO_W] ? rcdc_pkg::TXQ_XW'(-b_diff)
                                      : rcdc_pkg::TXQ_XW'(b_diff);
      e_neg <= e_diff[rcdc_pkg::CNT_W];
      e_mag <= e_diff[rcdc_pkg::CNT_W] ? rcdc_pkg::CRQ_XW'(-e_diff)
                                       : rcdc_pkg::CRQ_XW'(e_diff);
    end
    if (state == rcdc_pkg::B_QUOT) begin
      q_rx <= rxq_prod[rcdc_pkg::RXQ_PW-1:rcdc_pkg::RXQ_SH];
      q_tx <= txq_prod[rcdc_pkg::TXQ_PW-1:rcdc_pkg::TXQ_SH];
      q_c  <= crq_prod[rcdc_pkg::CRQ_PW-1:rcdc_pkg::CRQ_SH];
    end
    if (state == rcdc_pkg::B_REM) begin
      rem <= rcdc_pkg::FNQ_XW'(e_mag - c_back);
    end
    if (state == rcdc_pkg::B_APPLY) begin
      q_f <= fnq_prod[rcdc_pkg::FNQ_PW-1:rcdc_pkg::FNQ_SH];
    end
  end

  // Settings, trims and configuration loads
  always_ff @(posedge clk) begin
    if (rst) begin
      target     <= rcdc_pkg::TARGET_RESET;
      rx_cand[0] <= rcdc_pkg::SETTING_RESET;
      rx_cand[1] <= rcdc_pkg::SETTING_RESET;
      tx_cand[0] <= rcdc_pkg::SETTING_RESET;
      tx_cand[1] <= rcdc_pkg::SETTING_RESET;
      pair       <= 1'b0;
      coarse     <= rcdc_pkg::TRIM_RESET;
      fine       <= rcdc_pkg::TRIM_RESET;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          rcdc_pkg::REG_TARGET_COUNT: target     <= cfg.data;
          rcdc_pkg::REG_RX_DEFAULT:   rx_cand[0] <= cfg.data[rcdc_pkg::SET_W-1:0];
          rcdc_pkg::REG_RX_ALTERNATE: rx_cand[1] <= cfg.data[rcdc_pkg::SET_W-1:0];
          rcdc_pkg::REG_TX_DEFAULT:   tx_cand[0] <= cfg.data[rcdc_pkg::SET_W-1:0];
          rcdc_pkg::REG_TX_ALTERNATE: tx_cand[1] <= cfg.data[rcdc_pkg::SET_W-1:0];
          rcdc_pkg::REG_COARSE_INIT:  coarse     <= cfg.data[rcdc_pkg::TRIM_W-1:0];
          rcdc_pkg::REG_FINE_INIT:    fine       <= cfg.data[rcdc_pkg::TRIM_W-1:0];
          default: ;
        endcase
      end
      if (state == rcdc_pkg::B_REM) begin
        rx_cand[pair] <= rx_cand[pair] + rx_adj;
        tx_cand[pair] <= tx_cand[pair] - tx_adj;
        coarse        <= trim_add(coarse, q_c, e_neg);
      end
      if (state == rcdc_pkg::B_FIX) begin
        fine    <= fine_upd;
        pair    <= ~pair;
        rx_cand <= rx_fix;
        tx_cand <= tx_fix;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: radio_clock_drift_calibrator frame-by-frame check
// Drives acknowledgement frames through the input queue, predicts every
// result in lockstep with its own model of the window averaging and the
// oscillator corrections, and compares each popped result field by field.
// ---------------------------------------------------------------------------
module testbench;
  import rcdc_pkg::*;

  // Predictor constants, independent of the package values.
  localparam int               WINDOW_FRAMES = 10;
  localparam logic [6:0]       LEN_OK        = 7'd5;
  localparam int               IF_MID        = 500;
  localparam int               IF_DIV        = 17;
  localparam int               FO_MID        = 2;
  localparam int               FO_DIV        = 10;
  localparam int               CRS_DIV       = 331;
  localparam int               FIN_DIV       = 58;
  localparam logic [15:0]      RX_HOP        = 16'd26;
  localparam logic [15:0]      TX_HOP        = 16'd24;
  localparam logic [4:0]       EDGE_UP       = 5'd30;
  localparam logic [4:0]       EDGE_DN       = 5'd2;
  localparam logic [2:0]       REG_UNMAPPED  = 3'd7;

  // Run shape
  localparam int PHASES           = 9;
  localparam int FRAMES_PER_PHASE = 150;
  localparam int HOLD_CYCLES      = 200;
  localparam int SETTLE_CYCLES    = 12;
  localparam int TIMEOUT_NS       = 4_000_000;

  // Results straight after reset, for the rows of the directed list that
  // leave the state alone.
  localparam result_t IDLE_REJECT =
      '{1'b0, 1'b0, 16'd24576, 16'd24576, 5'd0, 5'd0, 1'b0};
  localparam result_t IDLE_ACCEPT =
      '{1'b1, 1'b0, 16'd24576, 16'd24576, 5'd0, 5'd0, 1'b0};

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  push;
  logic                  full;
  item_t                 ack_frame;
  logic                  empty;
  logic                  pop;
  result_t               cal_result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Typed expectation riding along with the frame being offered
  bit      row_typed;
  result_t row_want;

  // Idle control shared by the sender and receiver processes
  int push_gap_pct;
  int pop_gap_pct;
  bit hold_request;

  // Predicted block state
  logic [23:0] cal_target       = 24'd60000;
  cand_pair_t  rx_cand          = {16'd24576, 16'd24576};
  cand_pair_t  tx_cand          = {16'd24576, 16'd24576};
  logic        pair             = 1'b0;
  logic [4:0]  coarse           = 5'd0;
  logic [4:0]  fine             = 5'd0;
  int          if_acc           = 0;
  int          fo_acc           = 0;
  int          cnt_acc          = 0;
  int          frames_in_window = 0;

  result_t pending_results[$];

  int mismatches         = 0;
  int results_checked    = 0;
  int frames_sent        = 0;
  int frames_rejected    = 0;
  int windows_closed     = 0;
  int register_writes    = 0;
  int input_stall_cycles = 0;

  radio_clock_drift_calibrator i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (ack_frame),
    .empty     (empty),
    .pop       (pop),
    .result    (cal_result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  function automatic logic [4:0] clamp_trim(int v);
    if (v < 0) return 5'd0;
    if (v > 31) return 5'd31;
    return 5'(v);
  endfunction

  // First candidate (0 then 1) with its fine field at an edge is rebuilt from
  // the other one, hopping up from the top edge or down from the bottom one.
  function automatic cand_pair_t recenter(cand_pair_t c, logic [15:0] hop);
    cand_pair_t r;
    logic [4:0] lo;
    r = c;
    for (int i = 0; i < 2; i++) begin
      lo = c[i][4:0];
      if (lo >= EDGE_UP) begin
        r[i] = c[1-i] + hop;
        return r;
      end
      if (lo <= EDGE_DN) begin
        r[i] = c[1-i] - hop;
        return r;
      end
    end
    return r;
  endfunction

  // Advances the predicted state by one frame and returns the result the
  // block must report for it.
  function automatic result_t calibrate_frame(item_t f);
    result_t r;
    int avg_if, avg_fo, avg_cnt, step, err, q;
    logic ok, closed;
    ok = f.crc_good && (f.frame_length == LEN_OK);
    closed = 1'b0;
    if (ok) begin
      if_acc  += int'(f.if_estimate);
      fo_acc  += int'($signed(f.freq_offset));
      cnt_acc += int'(f.osc_count);
      frames_in_window++;
      if (frames_in_window >= WINDOW_FRAMES) begin
        avg_if  = if_acc / WINDOW_FRAMES;
        avg_fo  = fo_acc / WINDOW_FRAMES;     // truncates toward zero
        avg_cnt = cnt_acc / WINDOW_FRAMES;

        step = (avg_if - IF_MID) / IF_DIV;
        rx_cand[pair] = rx_cand[pair] + 16'(step);
        step = (avg_fo - FO_MID) / FO_DIV;
        tx_cand[pair] = tx_cand[pair] - 16'(step);

        // coarse takes whole steps of the error, fine takes the remainder
        err = avg_cnt - int'(cal_target);
        q = err / CRS_DIV;
        coarse = clamp_trim(int'(coarse) + q);
        err = err - q * CRS_DIV;
        fine = clamp_trim(int'(fine) + err / FIN_DIV);

        pair = ~pair;
        rx_cand = recenter(rx_cand, RX_HOP);
        tx_cand = recenter(tx_cand, TX_HOP);

        if_acc = 0;
        fo_acc = 0;
        cnt_acc = 0;
        frames_in_window = 0;
        closed = 1'b1;
      end
    end
    r.accepted          = ok;
    r.update_done       = closed;
    r.active_tx_setting = tx_cand[pair];
    r.active_rx_setting = rx_cand[pair];
    r.coarse_trim       = coarse;
    r.fine_trim         = fine;
    r.active_pair       = pair;
    return r;
  endfunction

  // Setting writes load the live candidate or trim at once.
  function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_TARGET_COUNT: cal_target = d[23:0];
      REG_RX_DEFAULT:   rx_cand[0] = d[15:0];
      REG_RX_ALTERNATE: rx_cand[1] = d[15:0];
      REG_TX_DEFAULT:   tx_cand[0] = d[15:0];
      REG_TX_ALTERNATE: tx_cand[1] = d[15:0];
      REG_COARSE_INIT:  coarse = d[4:0];
      REG_FINE_INIT:    fine = d[4:0];
      default: ;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Scoreboard: checks popped results, queues a prediction for every
  // frame taken and mirrors register writes. Everything is sampled at the
  // clock edge, before the block's own updates land.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("result transfer with no frame outstanding");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (cal_result.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d",
                   want.accepted, cal_result.accepted);
            mismatches++;
          end
          if (cal_result.update_done !== want.update_done) begin
            $error("update_done: expected %0d, got %0d",
                   want.update_done, cal_result.update_done);
            mismatches++;
          end
          if (cal_result.active_tx_setting !== want.active_tx_setting) begin
            $error("active_tx_setting: expected %0h, got %0h",
                   want.active_tx_setting, cal_result.active_tx_setting);
            mismatches++;
          end
          if (cal_result.active_rx_setting !== want.active_rx_setting) begin
            $error("active_rx_setting: expected %0h, got %0h",
                   want.active_rx_setting, cal_result.active_rx_setting);
            mismatches++;
          end
          if (cal_result.coarse_trim !== want.coarse_trim) begin
            $error("coarse_trim: expected %0d, got %0d",
                   want.coarse_trim, cal_result.coarse_trim);
            mismatches++;
          end
          if (cal_result.fine_trim !== want.fine_trim) begin
            $error("fine_trim: expected %0d, got %0d",
                   want.fine_trim, cal_result.fine_trim);
            mismatches++;
          end
          if (cal_result.active_pair !== want.active_pair) begin
            $error("active_pair: expected %0d, got %0d",
                   want.active_pair, cal_result.active_pair);
            mismatches++;
          end
        end
      end

      if (push && full) input_stall_cycles++;

      if (push && !full) begin
        // predictor runs on every frame so its state stays in step even
        // where the row carries a hand-written expectation
        want = calibrate_frame(ack_frame);
        if (row_typed) want = row_want;
        pending_results.push_back(want);
        frames_sent++;
        if (!want.accepted) frames_rejected++;
        if (want.update_done) windows_closed++;
      end

      if (cfg_valid && cfg_ready) begin
        load_register(cfg_index, cfg_data);
        register_writes++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Receiver: pops with random stall bursts, plus one long hold-off on
  // request so the block backs up and pushes back on the sender.
  // -------------------------------------------------------------------------
  initial begin : receiver
    pop <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (pop_gap_pct != 0 && $urandom_range(1, 100) <= pop_gap_pct) begin
        // the loop's own edge also adds to the idle burst
        pop <= 1'b0;
        repeat ($urandom_range(0, 18)) @(posedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sender helpers
  // -------------------------------------------------------------------------

  function automatic item_t make_frame(bit crc, int len, int ife, int fo, int cnt);
    item_t f;
    f.crc_good     = crc;
    f.frame_length = 7'(len);
    f.if_estimate  = 16'(ife);
    f.freq_offset  = 8'(fo);
    f.osc_count    = 24'(cnt);
    return f;
  endfunction

  // Mostly good frames with content near the operating point so windows
  // close often and corrections stay moderate; the rest is bad CRC, bad
  // length and full-range values.
  function automatic item_t random_frame();
    item_t f;
    int kind, c;
    kind = $urandom_range(0, 99);
    f.crc_good     = (kind < 92);
    f.frame_length = (kind < 85) ? LEN_OK : 7'($urandom_range(0, 127));
    if ($urandom_range(0, 9) < 7) f.if_estimate = 16'($urandom_range(0, 1500));
    else f.if_estimate = 16'($urandom);
    if ($urandom_range(0, 1) == 1) f.freq_offset = 8'(int'($urandom_range(0, 40)) - 20);
    else f.freq_offset = 8'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      c = int'(cal_target) + int'($urandom_range(0, 80000)) - 40000;
      if (c < 0) c = 0;
      if (c > 16777215) c = 16777215;
      f.osc_count = 24'(c);
    end else begin
      f.osc_count = 24'($urandom);
    end
    return f;
  endfunction

  // Phase 0 writes all zeros, phase 1 all ones, phase 2 parks candidates on
  // the fine-field edges; the rest are random, target often near nominal.
  function automatic logic [23:0] register_value(int phase, int r);
    case (phase)
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: begin
        case (3'(r))
          REG_TARGET_COUNT: return 24'd60000;
          REG_RX_DEFAULT:   return 24'h00601E;
          REG_RX_ALTERNATE: return 24'h006002;
          REG_TX_DEFAULT:   return 24'h00601F;
          REG_TX_ALTERNATE: return 24'h006001;
          default:          return 24'd16;
        endcase
      end
      default: begin
        if (3'(r) == REG_TARGET_COUNT && $urandom_range(0, 1) == 1)
          return 24'($urandom_range(30000, 90000));
        return 24'($urandom);
      end
    endcase
  endfunction

  // Offers one frame and returns right after the edge that takes it. Push
  // stays high into the next frame unless a gap is drawn.
  task automatic send_frame(item_t f, bit typed, result_t want);
    if (push_gap_pct != 0 && $urandom_range(1, 100) <= push_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push      <= 1'b1;
    ack_frame <= f;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Valid is left high across back-to-back writes; the caller drops it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Every frame yields a result, so once the last one is out the block is
  // idle; the task then waits out SETTLE_CYCLES before it returns.
  task automatic wait_until_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t plan[$];

    push         <= 1'b0;
    ack_frame    <= '0;
    row_typed    <= 1'b0;
    row_want     <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    push_gap_pct = 25;
    pop_gap_pct  = 25;
    hold_request = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, on reset settings. Rejected frames: bad CRC, lengths
    // at both extremes and either side of five, with extreme, patterned and nominal fields.
    plan.push_back('{make_frame(0, 5, 0, 0, 0), 1'b1, IDLE_REJECT});
    plan.push_back('{make_frame(1, 0, 65535, -1, 24'hFFFFFF), 1'b1, IDLE_REJECT});
    plan.push_back('{make_frame(1, 127, 16'hAAAA, 85, 24'h555555), 1'b1, IDLE_REJECT});
    plan.push_back('{make_frame(1, 4, 500, 2, 60000), 1'b1, IDLE_REJECT});
    plan.push_back('{make_frame(1, 6, 500, 2, 60000), 1'b1, IDLE_REJECT});
    plan.push_back('{make_frame(0, 127, 65535, -128, 24'hFFFFFF), 1'b1, IDLE_REJECT});
    // Nine good frames only fill the window: state unchanged
    plan.push_back('{make_frame(1, 5, 0, -128, 0), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 65535, 127, 24'hFFFFFF), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 16'hAAAA, 85, 24'h555555), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 16'h5555, -86, 24'hAAAAAA), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 500, 2, 60000), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 499, 1, 59999), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 501, 3, 60001), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 1000, -20, 61000), 1'b1, IDLE_ACCEPT});
    plan.push_back('{make_frame(1, 5, 0, 0, 59000), 1'b1, IDLE_ACCEPT});
    // Tenth closes the window: corrections, pair toggle, and the reset
    // settings sit on the bottom fine edge so both lists get re-centred.
    plan.push_back('{make_frame(1, 5, 700, 12, 60331), 1'b0, '0});
    plan.push_back('{make_frame(0, 5, 700, 12, 60331), 1'b0, '0});
    plan.push_back('{make_frame(1, 5, 520, -60, 59500), 1'b0, '0});
    plan.push_back('{make_frame(1, 5, 480, 40, 60700), 1'b0, '0});
    plan.push_back('{make_frame(1, 5, 900, -128, 62000), 1'b0, '0});
    plan.push_back('{make_frame(1, 5, 100, 127, 58000), 1'b0, '0});

    foreach (plan[i]) send_frame(plan[i].stim, plan[i].typed, plan[i].want);
    wait_until_drained();

    // Random phases, each opened by a full set of register writes
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int r = 0; r <= int'(REG_FINE_INIT); r++)
        write_reg(CFG_IDX_W'(r), register_value(phase, r));
      if (phase == 2) write_reg(REG_UNMAPPED, 24'hFFFFFF);
      cfg_valid <= 1'b0;

      case (phase)
        1: begin
          push_gap_pct = 0;
          pop_gap_pct  = 0;
        end
        2: begin
          push_gap_pct = 10;
          pop_gap_pct  = 50;
        end
        3: begin
          // receiver stops for a long stretch while frames keep coming
          push_gap_pct = 0;
          pop_gap_pct  = 10;
          hold_request = 1'b1;
        end
        PHASES - 1: begin
          push_gap_pct = 0;
          pop_gap_pct  = 0;
        end
        default: begin
          push_gap_pct = $urandom_range(0, 50);
          pop_gap_pct  = $urandom_range(0, 50);
        end
      endcase

      repeat (FRAMES_PER_PHASE) send_frame(random_frame(), 1'b0, '0);
      wait_until_drained();
    end

    $display("Sent %0d frames (%0d rejected), %0d windows closed, %0d register writes.",
             frames_sent, frames_rejected, windows_closed, register_writes);
    $display("Compared %0d results; input held off by a full block on %0d cycles.",
             results_checked, input_stall_cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
